// File: rtl/facc_pkg.sv
package facc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int MAX_COST   = 100000;

  localparam logic [CFG_IDX_W-1:0] CFG_WB_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_COST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_COST = 3'd4;

  localparam logic [1:0] FN_READ   = 2'd0;
  localparam logic [1:0] FN_WRITE  = 2'd1;
  localparam logic [1:0] FN_REVEAL = 2'd2;
  localparam logic [1:0] FN_FLUSH  = 2'd3;

  localparam logic [2:0] MOP_NONE   = 3'd0;
  localparam logic [2:0] MOP_FILL   = 3'd1;
  localparam logic [2:0] MOP_WB     = 3'd2;
  localparam logic [2:0] MOP_WT     = 3'd3;
  localparam logic [2:0] MOP_REVEAL = 3'd4;
  localparam logic [2:0] MOP_FLUSH  = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] address;
    logic [6:0]  cell_count;
    logic [4:0]  victim_pick;
  } req_t;

  typedef struct packed {
    logic [2:0]  mem_op;
    logic [31:0] mem_address;
    logic [6:0]  mem_length;
    logic        hit;
    logic [4:0]  slot;
    logic        slot_valid;
    logic [5:0]  cell_offset;
    logic [39:0] time_total;
    logic [31:0] read_hits;
    logic [31:0] writebacks;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_HIT,
    ACT_WB_VICTIM,
    ACT_FILL,
    ACT_WT,
    ACT_REVEAL,
    ACT_WB_FLUSH,
    ACT_FLUSH_DONE
  } act_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_FILL,
    S_FLUSH,
    S_FDONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic look;
    act_e act;
    logic add_time;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       wb_mode;
    logic       hit;
    logic       need_wb;
    logic       flush_wb;
    logic       walk_end;
    logic       out_free;
  } stat_t;

endpackage

// File: rtl/full_assoc_cache_controller_unit.sv
// Tag and policy controller of a fully associative cache with random replacement.
// Requests enter on in_valid/in_ready as one word per access (read, write, reveal
// or flush); memory commands and data store slot selects leave on out_valid/
// out_ready, one or more words per request, the final one flagged by last.
// Configuration words are written on cfg_valid/cfg_ready; the user must write
// them only while the block is idle, which the block itself does not enforce.
// One request is processed at a time. A hit, reveal or write-through issues a
// single word; a miss issues a fill word, preceded by a victim writeback word
// when no slot is free and the victim is dirty in write-back mode. A flush walks
// one slot per cycle over the configured slots, pausing while a writeback waits
// for the output register, then issues its final word. The next request is
// accepted in the cycle after the last word is issued.
// The output register holds a word until it is taken; a stalled receiver holds
// the controller in place without losing state.
// Reset clears all valid and dirty bits, the counters and the configuration to
// its defaults; tags need no clearing.
module full_assoc_cache_controller_unit import facc_pkg::*; #(
  parameter int SLOTS     = 32,
  parameter int ADDR_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  req_t                  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output res_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  facc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  facc_dp #(
    .SLOTS     (SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: rtl/facc_dp.sv
module facc_dp import facc_pkg::*; #(
  parameter int SLOTS     = 32,
  parameter int ADDR_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  req_t                  in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output stat_t                 st,
  input  logic                  out_ready,
  output logic                  out_valid,
  output res_t                  out_data
);

  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW  = $clog2(SLOTS + 1);
  localparam int TW  = ADDR_BITS - 4;

  logic                  wb_mode_r;
  logic [2:0]            lg_cfg_r;
  logic [5:0]            slots_cfg_r;
  logic [CFG_DATA_W-1:0] rcost_r;
  logic [CFG_DATA_W-1:0] wcost_r;

  req_t                  inp_r;
  logic [TW-1:0]         tag_r [SLOTS];
  logic [SLOTS-1:0]      valid_r;
  logic [SLOTS-1:0]      dirty_r;
  logic [SLOTS-1:0]      valid_nxt;
  logic [SLOTS-1:0]      dirty_nxt;

  logic                  hit_r;
  logic [SIW-1:0]        hit_idx_r;
  logic [SIW-1:0]        alloc_idx_r;
  logic                  need_wb_r;
  logic [SIW-1:0]        walk_r;

  logic [39:0]           time_r;
  logic [39:0]           time_nxt;
  logic [31:0]           hits_r;
  logic [31:0]           hits_nxt;
  logic [31:0]           wbs_r;
  logic [31:0]           wbs_nxt;

  logic                  out_valid_r;
  res_t                  out_r;
  res_t                  out_nxt;

  logic [2:0]            lg;
  logic [NW-1:0]         eff_n;
  logic [6:0]            bsize;
  logic [ADDR_BITS-1:0]  addr_m;
  logic [TW-1:0]         tag_q;
  logic [1:0]            low_mask;
  logic [ADDR_BITS-1:0]  aligned;
  logic [5:0]            off;
  logic [6:0]            room;
  logic [6:0]            cnt;
  logic [SLOTS-1:0]      match;
  logic [SLOTS-1:0]      free;
  logic                  m_found;
  logic [SIW-1:0]        m_idx;
  logic                  f_found;
  logic [SIW-1:0]        f_idx;
  logic [SIW-1:0]        victim;
  logic [SIW-1:0]        alloc;
  logic [SIW-1:0]        wb_idx;
  logic [ADDR_BITS-1:0]  wb_addr;
  logic [CFG_DATA_W-1:0] cost_raw;
  logic [CFG_DATA_W-1:0] cost;
  logic [40:0]           time_sum;

  always_comb begin
    if (lg_cfg_r < 3'd4) begin
      lg = 3'd4;
    end else if (lg_cfg_r > 3'd6) begin
      lg = 3'd6;
    end else begin
      lg = lg_cfg_r;
    end
    if (slots_cfg_r == 6'd0) begin
      eff_n = NW'(1);
    end else if (int'(slots_cfg_r) > SLOTS) begin
      eff_n = NW'(SLOTS);
    end else begin
      eff_n = NW'(slots_cfg_r);
    end
    bsize    = 7'd1 << lg;
    addr_m   = ADDR_BITS'(inp_r.address);
    low_mask = (lg == 3'd6) ? 2'd3 : ((lg == 3'd5) ? 2'd1 : 2'd0);
    tag_q    = addr_m[ADDR_BITS-1:4] & ~TW'(low_mask);
    aligned  = {tag_q, 4'b0000};
    off      = addr_m[5:0] & 6'(bsize - 7'd1);
    room     = bsize - {1'b0, off};
    cnt      = (inp_r.cell_count > room) ? room : inp_r.cell_count;
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = valid_r[i] && (tag_r[i] == tag_q) && (i < int'(eff_n));
      free[i]  = !valid_r[i] && (i < int'(eff_n));
    end
    m_found = 1'b0;
    m_idx   = '0;
    f_found = 1'b0;
    f_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        m_found = 1'b1;
        m_idx   = SIW'(i);
      end
      if (free[i]) begin
        f_found = 1'b1;
        f_idx   = SIW'(i);
      end
    end
    if (int'(inp_r.victim_pick) >= int'(eff_n)) begin
      victim = SIW'(eff_n - NW'(1));
    end else begin
      victim = SIW'(inp_r.victim_pick);
    end
    alloc = f_found ? f_idx : victim;
  end

  always_comb begin
    cost_raw = (inp_r.func == FN_READ) ? rcost_r : wcost_r;
    if (cost_raw == '0) begin
      cost = CFG_DATA_W'(1);
    end else if (int'(cost_raw) > MAX_COST) begin
      cost = CFG_DATA_W'(MAX_COST);
    end else begin
      cost = cost_raw;
    end
    time_sum = {1'b0, time_r} + 41'(cost);
    time_nxt = time_r;
    if (cmd.add_time) begin
      time_nxt = time_sum[40] ? '1 : time_sum[39:0];
    end
  end

  always_comb begin
    wb_idx    = (cmd.act == ACT_WB_FLUSH) ? walk_r : alloc_idx_r;
    wb_addr   = {tag_r[wb_idx], 4'b0000};
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    hits_nxt  = hits_r;
    wbs_nxt   = wbs_r;
    out_nxt   = '0;
    out_nxt.last = 1'b1;
    case (cmd.act)
      ACT_HIT: begin
        if (inp_r.func == FN_READ && hits_r != '1) begin
          hits_nxt = hits_r + 32'd1;
        end
        if (inp_r.func == FN_WRITE) begin
          dirty_nxt[hit_idx_r] = 1'b1;
        end
        out_nxt.mem_op      = MOP_NONE;
        out_nxt.hit         = 1'b1;
        out_nxt.slot        = 5'(hit_idx_r);
        out_nxt.slot_valid  = 1'b1;
        out_nxt.cell_offset = off;
      end
      ACT_WB_VICTIM, ACT_WB_FLUSH: begin
        if (wbs_r != '1) begin
          wbs_nxt = wbs_r + 32'd1;
        end
        dirty_nxt[wb_idx]   = 1'b0;
        out_nxt.mem_op      = MOP_WB;
        out_nxt.mem_address = 32'(wb_addr);
        out_nxt.mem_length  = bsize;
        out_nxt.slot        = 5'(wb_idx);
        out_nxt.slot_valid  = 1'b1;
        out_nxt.last        = 1'b0;
      end
      ACT_FILL: begin
        valid_nxt[alloc_idx_r] = 1'b1;
        dirty_nxt[alloc_idx_r] = (inp_r.func == FN_WRITE);
        out_nxt.mem_op      = MOP_FILL;
        out_nxt.mem_address = 32'(aligned);
        out_nxt.mem_length  = bsize;
        out_nxt.slot        = 5'(alloc_idx_r);
        out_nxt.slot_valid  = 1'b1;
        out_nxt.cell_offset = off;
      end
      ACT_WT, ACT_REVEAL: begin
        out_nxt.mem_op      = (cmd.act == ACT_WT) ? MOP_WT : MOP_REVEAL;
        out_nxt.mem_address = 32'(addr_m);
        out_nxt.mem_length  = cnt;
        out_nxt.hit         = hit_r;
        out_nxt.slot        = hit_r ? 5'(hit_idx_r) : 5'd0;
        out_nxt.slot_valid  = hit_r;
        out_nxt.cell_offset = hit_r ? off : 6'd0;
      end
      ACT_FLUSH_DONE: begin
        out_nxt.mem_op = MOP_FLUSH;
      end
      default: begin
        out_nxt.mem_op = MOP_NONE;
      end
    endcase
    out_nxt.time_total = time_nxt;
    out_nxt.read_hits  = hits_nxt;
    out_nxt.writebacks = wbs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_mode_r   <= 1'b0;
      lg_cfg_r    <= 3'd4;
      slots_cfg_r <= 6'd32;
      rcost_r     <= CFG_DATA_W'(1);
      wcost_r     <= CFG_DATA_W'(1);
      valid_r     <= '0;
      dirty_r     <= '0;
      time_r      <= '0;
      hits_r      <= '0;
      wbs_r       <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      need_wb_r   <= 1'b0;
      walk_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WB_MODE:    wb_mode_r   <= cfg_data[0];
          CFG_BLOCK_LOG2: lg_cfg_r    <= cfg_data[2:0];
          CFG_SLOTS:      slots_cfg_r <= cfg_data[5:0];
          CFG_READ_COST:  rcost_r     <= cfg_data;
          CFG_WRITE_COST: wcost_r     <= cfg_data;
          default: begin
          end
        endcase
      end
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      time_r  <= time_nxt;
      hits_r  <= hits_nxt;
      wbs_r   <= wbs_nxt;
      if (cmd.act != ACT_NONE) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.look) begin
        hit_r     <= m_found;
        need_wb_r <= !f_found && wb_mode_r && dirty_r[victim];
      end
      if (cmd.capture) begin
        walk_r <= '0;
      end else if (cmd.step) begin
        walk_r <= walk_r + SIW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      inp_r <= in_data;
    end
    if (cmd.look) begin
      hit_idx_r   <= m_idx;
      alloc_idx_r <= alloc;
    end
    if (cmd.act == ACT_FILL) begin
      tag_r[alloc_idx_r] <= tag_q;
    end
    if (cmd.act != ACT_NONE) begin
      out_r <= out_nxt;
    end
  end

  assign st.func     = inp_r.func;
  assign st.wb_mode  = wb_mode_r;
  assign st.hit      = hit_r;
  assign st.need_wb  = need_wb_r;
  assign st.flush_wb = valid_r[walk_r] && wb_mode_r && dirty_r[walk_r];
  assign st.walk_end = (NW'(walk_r) == eff_n - NW'(1));
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_fill_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_FILL) |=> valid_r[$past(alloc_idx_r)])
    else $error("filled slot not marked valid");

  a_wb_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act != ACT_WB_VICTIM && cmd.act != ACT_WB_FLUSH) |=> $stable(wbs_r))
    else $error("writeback counter moved without a writeback");

endmodule

// File: rtl/facc_ctrl.sv
module facc_ctrl import facc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.act      = ACT_NONE;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = (st.func == FN_FLUSH) ? S_FLUSH : S_EXEC;
      end
      S_EXEC: begin
        if (st.out_free) begin
          state_nxt = S_IDLE;
          if (st.func == FN_REVEAL) begin
            cmd.act = ACT_REVEAL;
          end else if (st.func == FN_WRITE && !st.wb_mode) begin
            cmd.act      = ACT_WT;
            cmd.add_time = 1'b1;
          end else if (st.hit) begin
            cmd.act      = ACT_HIT;
            cmd.add_time = 1'b1;
          end else if (st.need_wb) begin
            cmd.act      = ACT_WB_VICTIM;
            cmd.add_time = 1'b1;
            state_nxt    = S_FILL;
          end else begin
            cmd.act      = ACT_FILL;
            cmd.add_time = 1'b1;
          end
        end
      end
      S_FILL: begin
        if (st.out_free) begin
          cmd.act   = ACT_FILL;
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (st.flush_wb) begin
          if (st.out_free) begin
            cmd.act  = ACT_WB_FLUSH;
            cmd.step = 1'b1;
          end
        end else begin
          cmd.step = 1'b1;
        end
        if (cmd.step && st.walk_end) begin
          state_nxt = S_FDONE;
        end
      end
      S_FDONE: begin
        if (st.out_free) begin
          cmd.act   = ACT_FLUSH_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act != ACT_NONE) |-> st.out_free)
    else $error("result issued while output register is full");

  a_victim_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_WB_VICTIM) |-> !st.hit)
    else $error("victim writeback on a hit");

endmodule
